FILE: rtl/core/xts_pkg.sv
package xts_pkg;

  // Queue between the classify front and the compute back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic             empty;
    logic [QCW-1:0]   count;
  } fifo_stat_t;

  // Register depth of one channel pipe and of the gain divider, counted
  // from the back stage that holds a popped word.
  localparam int CH_LAT = 68;
  localparam int GN_LAT = 34;

  // sRGB/D65 matrix, magnitudes scaled by 1e7, and their signs.
  localparam longint MAT_MAG [9] = '{
    64'd32404542, 64'd15371385, 64'd4985314,
    64'd9692660,  64'd18760108, 64'd415560,
    64'd556434,   64'd2040259,  64'd10572252
  };
  localparam bit MAT_NEG [9] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

  // Encoder constants, linear values in Q1.20.
  localparam logic [20:0] LIN_KNEE  = 21'd3282;       // floor(0.0031308 * 2^20)
  localparam logic [26:0] LIN_MUL   = 27'd84671220;   // 1292 * 65535, that is 12.92 * 100 * 65535
  localparam logic [38:0] LIN_RND   = 39'd52428800;   // 50 * 2^20
  localparam logic [19:0] RCP_100   = 20'd671089;     // ceil(2^26 / 100)
  localparam int          RCP_100_SH = 26;
  localparam logic [31:0] PWR_OFF   = 32'd57671680;   // 55 * 2^20
  localparam logic [46:0] PWR_RND   = 47'd524288000;  // 500 * 2^20
  localparam logic [26:0] RCP_1000  = 27'd68719477;   // ceil(2^36 / 1000)
  localparam int          RCP_1000_SH = 36;

  typedef struct packed {
    logic [20:0] r;
    logic [41:0] r2;
  } sq_t;

  typedef struct packed {
    logic [20:0] r;
    logic [40:0] r2;
    logic [60:0] r3;
  } cb_t;

  function automatic longint coef(input longint mag, input int frac);
    return ((mag << frac) + 64'd5000000) / 64'd10000000;
  endfunction

  // One result bit of a floored square root, with the running square kept.
  function automatic sq_t sqrt_step(input logic [40:0] n, input sq_t s, input int b);
    logic [43:0] t2;
    sq_t         o;
    t2 = 44'(s.r2) + (44'(s.r) << (b + 1)) + (44'(1) << (2 * b));
    o  = s;
    if (t2 <= 44'(n)) begin
      o.r  = s.r | (21'(1) << b);
      o.r2 = t2[41:0];
    end
    return o;
  endfunction

  // One result bit of a floored cube root, with square and cube kept.
  function automatic cb_t cbrt_step(input logic [60:0] n, input cb_t s, input int b);
    logic [43:0] t2;
    logic [65:0] t3;
    cb_t         o;
    t2 = 44'(s.r2) + (44'(s.r) << (b + 1)) + (44'(1) << (2 * b));
    t3 = 66'(s.r3) + ((66'(s.r2) * 66'd3) << b) + ((66'(s.r) * 66'd3) << (2 * b))
       + (66'(1) << (3 * b));
    o  = s;
    if (t3 <= 66'(n)) begin
      o.r  = s.r | (21'(1) << b);
      o.r2 = t2[40:0];
      o.r3 = t3[60:0];
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/xts_in_if.sv
interface xts_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] chroma_x;
  logic [15:0] chroma_y;
  logic [31:0] luminance;

  modport source (output valid, output chroma_x, output chroma_y, output luminance,
                  input ready);
  modport sink (input valid, input chroma_x, input chroma_y, input luminance,
                output ready);
endinterface

FILE: rtl/core/xts_out_if.sv
interface xts_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] gain;
  logic [15:0] encoded_red;
  logic [15:0] encoded_green;
  logic [15:0] encoded_blue;

  modport source (output valid, output valid_res, output gain, output encoded_red,
                  output encoded_green, output encoded_blue, input ready);
  modport sink (input valid, input valid_res, input gain, input encoded_red,
                input encoded_green, input encoded_blue, output ready);
endinterface

FILE: rtl/core/xts_fifo.sv
module xts_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   pop,
  output logic [WIDTH-1:0]       rdata,
  output xts_pkg::fifo_stat_t    stat
);

  logic [WIDTH-1:0]          mem [xts_pkg::QDEPTH];
  logic [xts_pkg::QAW-1:0]   wptr;
  logic [xts_pkg::QAW-1:0]   rptr;
  logic [xts_pkg::QCW-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  assign rdata      = mem[rptr];
  assign stat.empty = (count == '0);
  assign stat.count = count;

endmodule

FILE: rtl/core/xts_front.sv
module xts_front #(
  parameter int FRAC_BITS = 16,
  localparam int CW = FRAC_BITS + 20,
  localparam int MW = FRAC_BITS + 19,
  localparam int QW = 1 + 16 + 32 + 3 * CW + MW
) (
  input  logic                 clk,
  input  logic                 rst,
  xts_in_if.sink               pix_in,
  input  xts_pkg::fifo_stat_t  stat,
  output logic                 push,
  output logic [QW-1:0]        wdata
);

  localparam int CFW = FRAC_BITS + 3;
  localparam int PW  = CFW + 18;

  wire signed [CFW-1:0] coef_w [9];

  for (genvar gi = 0; gi < 9; gi++) begin : g_coef
    localparam longint MV = xts_pkg::coef(xts_pkg::MAT_MAG[gi], FRAC_BITS);
    assign coef_w[gi] = xts_pkg::MAT_NEG[gi] ? -CFW'(MV) : CFW'(MV);
  end

  logic signed [17:0]    term [3];
  logic                  v1, v2;
  logic                  vres1, vres2;
  logic [15:0]           y1, y2;
  logic [31:0]           lum1, lum2;
  logic signed [PW-1:0]  prod [3][3];
  logic signed [CW-1:0]  c [3];
  logic signed [CW-1:0]  mx;
  logic [xts_pkg::QCW:0] pending;

  always_comb begin
    term[0] = $signed({2'b00, pix_in.chroma_x});
    term[1] = $signed({2'b00, pix_in.chroma_y});
    term[2] = 18'sd65536 - term[0] - term[1];
  end

  // Count words already owed to the queue so it can never overflow.
  assign pending      = {1'b0, stat.count} + (xts_pkg::QCW + 1)'(v1)
                      + (xts_pkg::QCW + 1)'(v2);
  assign pix_in.ready = !rst && (pending < (xts_pkg::QCW + 1)'(xts_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= pix_in.valid && pix_in.ready;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    vres1 <= (pix_in.chroma_y != 16'd0);
    y1    <= pix_in.chroma_y;
    lum1  <= pix_in.luminance;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod[k][j] <= PW'(coef_w[k * 3 + j]) * PW'(term[j]);
      end
    end
    vres2 <= vres1;
    y2    <= y1;
    lum2  <= lum1;
    for (int k = 0; k < 3; k++) begin
      c[k] <= CW'(prod[k][0] + prod[k][1] + prod[k][2]);
    end
  end

  always_comb begin
    mx = '0;
    for (int k = 0; k < 3; k++) begin
      if (c[k] > mx) mx = c[k];
    end
  end

  assign push  = v2;
  assign wdata = {vres2, y2, lum2, c[0], c[1], c[2], mx[MW-1:0]};

endmodule

FILE: rtl/core/xts_chan.sv
module xts_chan #(
  parameter int FRAC_BITS = 16,
  localparam int CW = FRAC_BITS + 20,
  localparam int MW = FRAC_BITS + 19
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] c,
  input  logic [MW-1:0]        cmax,
  output logic [15:0]          code
);

  typedef struct packed {
    logic [MW-1:0] r;
    logic [20:0]   q;
  } dv_t;

  // Restoring divide step: one quotient bit of c * 2^20 / cmax.
  function automatic dv_t div_step(input dv_t s, input logic b, input logic [MW-1:0] d);
    logic [MW:0] t;
    dv_t         o;
    t = {s.r, b};
    if (t >= {1'b0, d}) begin
      o.r = MW'(t - {1'b0, d});
      o.q = {s.q[19:0], 1'b1};
    end else begin
      o.r = t[MW-1:0];
      o.q = {s.q[19:0], 1'b0};
    end
    return o;
  endfunction

  logic [MW-1:0]    cc;
  dv_t              dv [0:21];
  logic [20:0]      dn [0:21];
  logic [MW-1:0]    dm [0:21];
  logic [20:0]      p1v [1:21];
  xts_pkg::sq_t     sa [1:21];
  xts_pkg::cb_t     ca [1:21];
  logic [20:0]      p2v [1:21];
  logic [20:0]      p2a [1:21];
  logic [20:0]      p2c [1:21];
  xts_pkg::sq_t     sb [1:21];
  xts_pkg::sq_t     sc [1:21];

  logic             e1_lin, e2_lin, e3_lin, e4_lin;
  logic [41:0]      e1_prod;
  logic [38:0]      e1_lm;
  logic             e2_neg, e3_neg, e4_neg;
  logic [31:0]      e2_d;
  logic [18:0]      e2_tl;
  logic [25:0]      e3_t;
  logic [38:0]      e3_lm, e4_lm;
  logic [52:0]      e4_pm;

  logic [31:0]      hi;
  logic [46:0]      tp;
  logic [16:0]      pc;
  logic [15:0]      pcode;
  logic [15:0]      lcode;

  // Negative channels clamp to zero before the divide.
  assign cc = (c > 0) ? c[MW-1:0] : '0;
  assign hi = 32'(11'd1055 * e1_prod[41:20]);
  assign tp = (47'(e2_d) << 16) - 47'(e2_d) + xts_pkg::PWR_RND;

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= '{r: cc >> 1, q: '0};
      dn[0] <= {cc[0], 20'b0};
      dm[0] <= cmax;
      for (int k = 0; k < 21; k++) begin
        dv[k + 1] <= div_step(dv[k], dn[k][20], dm[k]);
        dn[k + 1] <= dn[k] << 1;
        dm[k + 1] <= dm[k];
      end

      // First roots: sqrt(v << 20) and cbrt(v << 40).
      p1v[1] <= dv[21].q;
      sa[1]  <= xts_pkg::sqrt_step({dv[21].q, 20'b0}, '0, 20);
      ca[1]  <= xts_pkg::cbrt_step({dv[21].q, 40'b0}, '0, 20);
      for (int j = 1; j < 21; j++) begin
        p1v[j + 1] <= p1v[j];
        sa[j + 1]  <= xts_pkg::sqrt_step({p1v[j], 20'b0}, sa[j], 20 - j);
        ca[j + 1]  <= xts_pkg::cbrt_step({p1v[j], 40'b0}, ca[j], 20 - j);
      end

      // Second roots give v^(1/4) and v^(1/6).
      p2v[1] <= p1v[21];
      p2a[1] <= sa[21].r;
      p2c[1] <= ca[21].r;
      sb[1]  <= xts_pkg::sqrt_step({sa[21].r, 20'b0}, '0, 20);
      sc[1]  <= xts_pkg::sqrt_step({ca[21].r, 20'b0}, '0, 20);
      for (int j = 1; j < 21; j++) begin
        p2v[j + 1] <= p2v[j];
        p2a[j + 1] <= p2a[j];
        p2c[j + 1] <= p2c[j];
        sb[j + 1]  <= xts_pkg::sqrt_step({p2a[j], 20'b0}, sb[j], 20 - j);
        sc[j + 1]  <= xts_pkg::sqrt_step({p2c[j], 20'b0}, sc[j], 20 - j);
      end

      e1_lin  <= (p2v[21] <= xts_pkg::LIN_KNEE);
      e1_prod <= 42'(sb[21].r * sc[21].r);
      e1_lm   <= 39'(p2v[21][11:0] * xts_pkg::LIN_MUL);

      e2_lin  <= e1_lin;
      e2_neg  <= (hi <= xts_pkg::PWR_OFF);
      e2_d    <= hi - xts_pkg::PWR_OFF;
      e2_tl   <= 19'((e1_lm + xts_pkg::LIN_RND) >> 20);

      e3_lin  <= e2_lin;
      e3_neg  <= e2_neg;
      e3_t    <= tp[45:20];
      e3_lm   <= 39'(e2_tl * xts_pkg::RCP_100);

      e4_lin  <= e3_lin;
      e4_neg  <= e3_neg;
      e4_pm   <= 53'(e3_t * xts_pkg::RCP_1000);
      e4_lm   <= e3_lm;
    end
  end

  always_comb begin
    pc    = e4_pm[52:xts_pkg::RCP_1000_SH];
    pcode = (pc > 17'd65535) ? 16'hFFFF : pc[15:0];
    if (e4_neg) pcode = '0;
    lcode = 16'(e4_lm >> xts_pkg::RCP_100_SH);
    code  = e4_lin ? lcode : pcode;
  end

endmodule

FILE: rtl/core/xts_back.sv
module xts_back #(
  parameter int FRAC_BITS = 16,
  localparam int CW = FRAC_BITS + 20,
  localparam int MW = FRAC_BITS + 19,
  localparam int QW = 1 + 16 + 32 + 3 * CW + MW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [QW-1:0]        rdata,
  input  xts_pkg::fifo_stat_t  stat,
  output logic                 pop,
  xts_out_if.source            pix_out
);

  localparam int HW = MW - 24;
  localparam int NW = MW + 32;
  localparam int GD = xts_pkg::CH_LAT - xts_pkg::GN_LAT;
  localparam int LT = xts_pkg::CH_LAT;

  typedef struct packed {
    logic [15:0] r;
    logic [31:0] q;
    logic [31:0] l;
  } gd_t;

  // Restoring divide step on the scaled luminance product.
  function automatic gd_t gdiv_step(input gd_t s, input logic [15:0] y);
    logic [16:0] t;
    gd_t         o;
    t   = {s.r, s.l[31]};
    o.l = s.l << 1;
    if (t >= {1'b0, y}) begin
      o.r = 16'(t - {1'b0, y});
      o.q = {s.q[30:0], 1'b1};
    end else begin
      o.r = t[15:0];
      o.q = {s.q[30:0], 1'b0};
    end
    return o;
  endfunction

  logic                 en;
  logic                 q_vres;
  logic [15:0]          q_y;
  logic [31:0]          q_lum;
  logic signed [CW-1:0] q_c0, q_c1, q_c2;
  logic [MW-1:0]        q_cmax;

  logic                 vb [0:LT];
  logic                 vr [0:LT];
  logic [15:0]          y0;
  logic [31:0]          lum0;
  logic signed [CW-1:0] c0 [3];
  logic [MW-1:0]        cmax0;

  logic [55:0]          plo;
  logic [31+HW:0]       phi;
  logic [15:0]          yg1;
  logic [NW-1:0]        nsum;
  logic [50:0]          np;
  logic [18:0]          hin;
  logic                 ovf;

  gd_t                  gs [0:32];
  logic [15:0]          gy [0:32];
  logic                 gsat [0:32];
  logic [31:0]          gd [1:GD];
  logic [15:0]          code [3];
  logic                 gz;

  assign {q_vres, q_y, q_lum, q_c0, q_c1, q_c2, q_cmax} = rdata;

  // The whole back pipe moves while the output register is free or drained.
  assign en  = !pix_out.valid || pix_out.ready;
  assign pop = en && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LT; k++) vb[k] <= 1'b0;
      pix_out.valid <= 1'b0;
    end else if (en) begin
      vb[0] <= !stat.empty;
      for (int k = 0; k < LT; k++) vb[k + 1] <= vb[k];
      pix_out.valid <= vb[LT];
    end
  end

  always_comb begin
    nsum = NW'(plo) + (NW'(phi) << 24);
    np   = nsum[NW-1:FRAC_BITS];
    hin  = np[50:32];
    ovf  = (hin >= {3'b000, yg1});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vr[0] <= q_vres;
      for (int k = 0; k < LT; k++) vr[k + 1] <= vr[k];
      y0    <= q_y;
      lum0  <= q_lum;
      c0[0] <= q_c0;
      c0[1] <= q_c1;
      c0[2] <= q_c2;
      cmax0 <= q_cmax;

      // Split cmax * Y into two partial products.
      plo <= 56'(lum0 * cmax0[23:0]);
      phi <= (32 + HW)'(lum0 * cmax0[MW-1:24]);
      yg1 <= y0;

      gs[0]   <= '{r: ovf ? 16'd0 : hin[15:0], q: '0, l: np[31:0]};
      gy[0]   <= yg1;
      gsat[0] <= ovf;
      for (int k = 0; k < 32; k++) begin
        gs[k + 1]   <= gdiv_step(gs[k], gy[k]);
        gy[k + 1]   <= gy[k];
        gsat[k + 1] <= gsat[k];
      end

      gd[1] <= gsat[32] ? 32'hFFFF_FFFF : gs[32].q;
      for (int k = 1; k < GD; k++) gd[k + 1] <= gd[k];
    end
  end

  for (genvar gc = 0; gc < 3; gc++) begin : g_ch
    xts_chan #(
      .FRAC_BITS(FRAC_BITS)
    ) u_chan (
      .clk  (clk),
      .en   (en),
      .c    (c0[gc]),
      .cmax (cmax0),
      .code (code[gc])
    );
  end

  assign gz = !vr[LT] || (gd[GD] == 32'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      pix_out.valid_res     <= vr[LT];
      pix_out.gain          <= vr[LT] ? gd[GD] : 32'd0;
      pix_out.encoded_red   <= gz ? 16'd0 : code[0];
      pix_out.encoded_green <= gz ? 16'd0 : code[1];
      pix_out.encoded_blue  <= gz ? 16'd0 : code[2];
    end
  end

endmodule

FILE: rtl/core/xyy_to_srgb_with_gain.sv
// Channel   Dir   Word
// pix_in    in    chroma_x[15:0], chroma_y[15:0], luminance[31:0]
// pix_out   out   valid_res, gain[31:0], encoded_red/green/blue[15:0]
//
// One word per cycle sustained while pix_out is not stalled; each word
// passes the matrix front, the queue and the back, whose depth the 21-step
// divide and the two 21-step root chains of each channel set.
// Synchronous reset clears all valid bits; no clearing pass.
// A stalled output holds the whole back pipe; the 4-deep queue then fills and
// drops pix_in.ready.
module xyy_to_srgb_with_gain #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  xts_in_if.sink     pix_in,
  xts_out_if.source  pix_out
);

  localparam int CW = FRAC_BITS + 20;
  localparam int MW = FRAC_BITS + 19;
  localparam int QW = 1 + 16 + 32 + 3 * CW + MW;

  logic                 push;
  logic                 pop;
  logic [QW-1:0]        wdata;
  logic [QW-1:0]        rdata;
  xts_pkg::fifo_stat_t  stat;

  xts_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix_in),
    .stat   (stat),
    .push   (push),
    .wdata  (wdata)
  );

  xts_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .stat  (stat)
  );

  xts_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .rdata   (rdata),
    .stat    (stat),
    .pop     (pop),
    .pix_out (pix_out)
  );

endmodule

FILE: rtl/core/xts_check.sv
module xts_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        valid_res,
  input logic [31:0] gain,
  input logic [15:0] red,
  input logic [15:0] green,
  input logic [15:0] blue
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gain) && $stable(red)
                                && $stable(green) && $stable(blue) && $stable(valid_res))
    else $error("stalled output word changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> gain == 32'd0 && red == 16'd0 && green == 16'd0
                                && blue == 16'd0)
    else $error("invalid chromaticity gave nonzero output");

  a_gain_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && gain == 32'd0 |-> red == 16'd0 && green == 16'd0 && blue == 16'd0)
    else $error("zero gain with nonzero channel");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid && gain != 32'd0 |-> red == 16'hFFFF || green == 16'hFFFF
                                   || blue == 16'hFFFF)
    else $error("no channel at full scale");

endmodule

bind xyy_to_srgb_with_gain xts_check u_xts_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .valid_res (pix_out.valid_res),
  .gain      (pix_out.gain),
  .red       (pix_out.encoded_red),
  .green     (pix_out.encoded_green),
  .blue      (pix_out.encoded_blue)
);

FILE: dv/xyy_to_srgb_with_gain_tb.sv
`timescale 1ns / 1ps

module xyy_to_srgb_with_gain_tb;

  typedef struct {
    bit        valid_res;
    bit [31:0] gain;
    bit [15:0] red;
    bit [15:0] green;
    bit [15:0] blue;
  } pix_res_t;

  localparam longint LIN_UNIT   = 64'd1 << 20;
  localparam int     NUM_RANDOM = 1800;
  localparam int     QUIET_FROM = 1550;
  localparam int     HOLD_AT    = 600;
  localparam int     HOLD_LEN   = 250;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  int   sent_cnt;
  bit   quiet;

  xts_in_if  pin ();
  xts_out_if pout ();

  xyy_to_srgb_with_gain dut (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pin.sink),
    .pix_out(pout.source)
  );

  function automatic bit [63:0] root2(input bit [63:0] n);
    bit [63:0] r;
    bit [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) <= 128'(n)) r = t;
    end
    return r;
  endfunction

  function automatic bit [63:0] root3(input bit [63:0] n);
    bit [63:0] r;
    bit [63:0] t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) * 128'(t) <= 128'(n)) r = t;
    end
    return r;
  endfunction

  function automatic bit [15:0] srgb_code(input bit [63:0] v);
    bit [63:0] q4;
    bit [63:0] q6;
    bit [63:0] p;
    bit [63:0] hi;
    bit [63:0] code;
    if (v > LIN_UNIT) v = LIN_UNIT;
    if (v * 64'd10000000 <= 64'd31308 * LIN_UNIT)
      return 16'((v * 64'd1292 * 64'd65535 + 64'd50 * LIN_UNIT) / (64'd100 * LIN_UNIT));
    q4 = root2(root2(v << 20) << 20);
    q6 = root2(root3(v << 40) << 20);
    p  = (q4 * q6) >> 20;
    hi = 64'd1055 * p;
    if (hi <= 64'd55 * LIN_UNIT) return 16'd0;
    code = ((hi - 64'd55 * LIN_UNIT) * 64'd65535 + 64'd500 * LIN_UNIT)
         / (64'd1000 * LIN_UNIT);
    return (code > 64'd65535) ? 16'hFFFF : code[15:0];
  endfunction

  function automatic pix_res_t convert_pixel(input bit [15:0] cx, input bit [15:0] cy,
                                             input bit [31:0] lum);
    pix_res_t   res;
    longint     term [3];
    longint     chan [3];
    longint     cmax;
    longint     m;
    bit [127:0] quo;
    bit [63:0]  v;
    res = '{default: 0};
    if (cy == 0) return res;
    res.valid_res = 1;
    term[0] = longint'(cx);
    term[1] = longint'(cy);
    term[2] = 65536 - longint'(cx) - longint'(cy);
    cmax = 0;
    for (int k = 0; k < 3; k++) begin
      chan[k] = 0;
      for (int j = 0; j < 3; j++) begin
        m = ((xts_pkg::MAT_MAG[k * 3 + j] << 16) + 5000000) / 10000000;
        chan[k] += (xts_pkg::MAT_NEG[k * 3 + j] ? -m : m) * term[j];
      end
      if (chan[k] > cmax) cmax = chan[k];
    end
    quo = (128'(cmax) * 128'(lum)) / (128'(cy) << 16);
    res.gain = (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    if (res.gain == 0) return res;
    for (int k = 0; k < 3; k++) begin
      v = 0;
      if (chan[k] > 0) begin
        quo = (128'(chan[k]) << 20) / 128'(cmax);
        v = (quo > 128'(LIN_UNIT)) ? LIN_UNIT : quo[63:0];
      end
      case (k)
        0: res.red   = srgb_code(v);
        1: res.green = srgb_code(v);
        default: res.blue = srgb_code(v);
      endcase
    end
    return res;
  endfunction

  class pixel_board;
    pix_res_t pending[$];
    int       errors;

    task report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void note(input bit [15:0] cx, input bit [15:0] cy, input bit [31:0] lum);
      pending = {pending, convert_pixel(cx, cy, lum)};
    endfunction

    task check(input pix_res_t got);
      pix_res_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.valid_res !== want.valid_res)
        report($sformatf("valid_res %0d want %0d", got.valid_res, want.valid_res));
      if (got.gain !== want.gain)
        report($sformatf("gain %h want %h", got.gain, want.gain));
      if (got.red !== want.red)
        report($sformatf("red %h want %h", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green %h want %h", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue %h want %h", got.blue, want.blue));
    endtask
  endclass

  pixel_board board;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    pin.valid     = 0;
    pin.chroma_x  = 0;
    pin.chroma_y  = 0;
    pin.luminance = 0;
    pout.ready    = 0;
    rst           = 1;
    board         = new();
    sent_cnt      = 0;
    quiet         = 0;
  end

  // Hold one word on the input until accepted, then maybe idle a burst.
  task send_pixel(input bit [15:0] cx, input bit [15:0] cy, input bit [31:0] lum);
    @(negedge clk);
    pin.valid     = 1;
    pin.chroma_x  = cx;
    pin.chroma_y  = cy;
    pin.luminance = lum;
    do @(posedge clk); while (!pin.ready);
    board.note(cx, cy, lum);
    sent_cnt++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      pin.valid = 0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk);
    end
  endtask

  task send_random_pixel();
    bit [15:0] cx;
    bit [15:0] cy;
    bit [31:0] lum;
    case ($urandom_range(0, 9))
      0, 1: begin
        cx  = 16'($urandom);
        cy  = 16'($urandom);
        lum = $urandom;
      end
      2: begin
        cx  = 16'($urandom);
        cy  = 16'($urandom_range(0, 3));
        lum = $urandom;
      end
      3: begin
        cx  = 16'($urandom_range(0, 65535));
        cy  = 16'($urandom_range(1, 65535));
        lum = $urandom_range(0, 4);
      end
      default: begin
        // plausible in-gamut colors with a spread of luminance scales
        cx  = 16'($urandom_range(9000, 48000));
        cy  = 16'($urandom_range(3000, 55000));
        lum = $urandom >> $urandom_range(0, 31);
      end
    endcase
    send_pixel(cx, cy, lum);
  endtask

  // Output side: random stalls, one long hold-off, none near the end.
  initial begin
    int gap;
    bit held;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && sent_cnt >= HOLD_AT) begin
        held = 1;
        pout.ready = 0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      if (!quiet && $urandom_range(0, 6) == 0) begin
        pout.ready = 0;
        gap = $urandom_range(1, 9);
        repeat (gap - 1) @(negedge clk);
      end else begin
        pout.ready = 1;
      end
    end
  end

  always @(posedge clk) begin
    pix_res_t got;
    if (!rst && pout.valid && pout.ready) begin
      got.valid_res = pout.valid_res;
      got.gain      = pout.gain;
      got.red       = pout.encoded_red;
      got.green     = pout.encoded_green;
      got.blue      = pout.encoded_blue;
      board.check(got);
    end
  end

  initial begin
    longint cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    #0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_pixel(16'd21268, 16'd21890, 32'h0001_0000);
    send_pixel(16'd1000, 16'd0, 32'hFFFF_FFFF);       // zero y
    send_pixel(16'hFFFF, 16'd0, 32'd0);
    send_pixel(16'd0, 16'd1, 32'hFFFF_FFFF);          // saturated gain
    send_pixel(16'hFFFF, 16'd1, 32'hFFFF_FFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_pixel(16'd0, 16'hFFFF, 32'd1);
    send_pixel(16'd21268, 16'd21890, 32'd0);          // gain truncates to zero
    send_pixel(16'd21268, 16'hFFFF, 32'd1);
    send_pixel(16'd41943, 16'd21627, 32'h0000_8000);  // red primary
    send_pixel(16'd19661, 16'd39322, 32'h0000_8000);  // green primary
    send_pixel(16'd9830, 16'd3932, 32'h0000_8000);    // blue primary
    send_pixel(16'd45000, 16'd8000, 32'h0010_0000);   // negative channels
    send_pixel(16'd5000, 16'd60000, 32'h0002_0000);
    send_pixel(16'd0, 16'd0, 32'd0);
    send_pixel(16'hFFFF, 16'hFFFF, 32'd1);
    send_pixel(16'd30000, 16'd30000, 32'h7FFF_FFFF);
    send_pixel(16'd20000, 16'd22000, 32'd3);          // small nonzero gain
    send_pixel(16'd32768, 16'd32768, 32'h0001_0000);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == QUIET_FROM) quiet = 1;
      send_random_pixel();
    end
    @(negedge clk);
    pin.valid = 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
